>>> sv/ecc_pkg.sv
// Shared types and constants for the elevator car controller.
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

   // Fixed field widths of the event and result words.
   localparam int FUNC_W      = 3;
   localparam int FLOOR_W     = 2;
   localparam int BUTTON_W    = 2;
   localparam int TICKS_W     = 16;
   localparam int LAMPS_W     = 12;
   localparam int NUM_BUTTONS = 3;
   localparam int SHOWN_FLOORS = LAMPS_W / NUM_BUTTONS;

   // Packed port widths.
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = FUNC_W;
   localparam int RSP_TDATA_W = 24;

   // Defaults.
   localparam int                 NUM_FLOORS_DEFAULT = 4;
   localparam logic [TICKS_W-1:0] DOOR_TICKS_RESET   = 16'd3000;

   // Event kinds.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK   = 3'd0,
      FUNC_SENSOR = 3'd1,
      FUNC_STOP   = 3'd2,
      FUNC_OBSTR  = 3'd3,
      FUNC_ORDER  = 3'd4
   } func_type;

   // Button kinds.
   localparam logic [BUTTON_W-1:0] BTN_HALL_UP   = 2'd0;
   localparam logic [BUTTON_W-1:0] BTN_HALL_DOWN = 2'd1;

   // Car modes.
   typedef enum logic [2:0] {
      MODE_UNKNOWN = 3'd0,
      MODE_CLOSED  = 3'd1,
      MODE_OPEN    = 3'd2,
      MODE_UP      = 3'd3,
      MODE_DOWN    = 3'd4,
      MODE_STOPPED = 3'd5,
      MODE_BETWEEN = 3'd6
   } mode_type;

   // Travel and motor directions.
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // One input event.
   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [FLOOR_W-1:0]  floor;
      logic [BUTTON_W-1:0] button;
      logic                level;
   } evt_type;

   // One result word.
   typedef struct packed {
      dir_type            motor_dir;
      logic               door_lamp;
      logic               stop_lamp;
      logic [FLOOR_W-1:0] floor_indicator;
      logic [LAMPS_W-1:0] order_lamps;
      mode_type           ctrl_mode;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/ecc_in_stage.sv
// Input register for the event stream.
`timescale 1ns / 1ps
`default_nettype none

module ecc_in_stage (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ecc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic [ecc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  wire logic                                advance,
   output logic                                     evt_valid,
   output ecc_pkg::evt_type                         evt
);
   import ecc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   evt_type evt_ff;

   // The register takes a new word when it is empty or drains this cycle.
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on acceptance only.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         evt_ff.func   <= req_tuser[FUNC_W-1:0];
         evt_ff.floor  <= req_tdata[FLOOR_W-1:0];
         evt_ff.button <= req_tdata[FLOOR_W +: BUTTON_W];
         evt_ff.level  <= req_tdata[FLOOR_W + BUTTON_W];
      end
   end

   assign evt_valid = valid_ff;
   assign evt       = evt_ff;

endmodule

`default_nettype wire

>>> sv/ecc_ctrl.sv
// Car state, order matrix, door timer and next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module ecc_ctrl #(
   parameter int NUM_FLOORS = ecc_pkg::NUM_FLOORS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [ecc_pkg::TICKS_W-1:0]     csr_wr_data,
   input  wire logic                            fire,
   input  wire ecc_pkg::evt_type                evt,
   output ecc_pkg::rsp_type                     rsp
);
   import ecc_pkg::*;

   localparam int SHOWN = (NUM_FLOORS < SHOWN_FLOORS) ? NUM_FLOORS : SHOWN_FLOORS;

   typedef logic [NUM_BUTTONS-1:0] row_type;
   typedef row_type [NUM_FLOORS-1:0] orders_type;

   // OR of all order rows from floor lo through floor hi.
   function automatic logic scan(orders_type ord, int lo, int hi);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_FLOORS; i++) begin
         if (i >= lo && i <= hi && ord[i] != '0) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Order row of one floor.
   function automatic row_type row_at(orders_type ord, logic [FLOOR_W-1:0] f);
      row_type r;
      r = '0;
      for (int i = 0; i < NUM_FLOORS; i++) begin
         if (i == int'(f)) begin
            r = ord[i];
         end
      end
      return r;
   endfunction

   // Where the car heads once the doors are done.
   function automatic mode_type next_mode(orders_type ord, logic [FLOOR_W-1:0] cf,
                                          dir_type ld);
      int       f;
      mode_type m;
      f = int'(cf);
      m = MODE_CLOSED;
      if (ld == DIR_DOWN) begin
         if (scan(ord, 0, f - 1)) begin
            m = MODE_DOWN;
         end else if (scan(ord, f, NUM_FLOORS - 1)) begin
            m = MODE_UP;
         end
      end else begin
         if (scan(ord, f + 1, NUM_FLOORS - 1)) begin
            m = MODE_UP;
         end else if (scan(ord, 0, f)) begin
            m = MODE_DOWN;
         end
      end
      return m;
   endfunction

   // Whether the car stops at the floor it just reached.
   function automatic logic stop_here(orders_type ord, logic [FLOOR_W-1:0] cf,
                                      mode_type md);
      int      f;
      row_type r;
      logic    s;
      f = int'(cf);
      r = row_at(ord, cf);
      s = 1'b0;
      case (md)
         MODE_DOWN: begin
            s = (r & ~(row_type'(1) << BTN_HALL_UP)) != '0 ||
                !scan(ord, 0, f - 1);
         end
         MODE_UP: begin
            s = (r & ~(row_type'(1) << BTN_HALL_DOWN)) != '0 ||
                !scan(ord, f + 1, NUM_FLOORS - 1);
         end
         MODE_CLOSED, MODE_OPEN: begin
            s = (r != '0);
         end
         default: begin
            s = 1'b0;
         end
      endcase
      return s;
   endfunction

   logic [TICKS_W-1:0] ticks_ff;
   mode_type           mode_ff, mode_in;
   dir_type            last_dir_ff, last_dir_in;
   logic [FLOOR_W-1:0] car_floor_ff, car_floor_in;
   orders_type         orders_ff, orders_in;
   logic [TICKS_W-1:0] countdown_ff, countdown_in;
   logic               armed_ff, armed_in;
   dir_type            motor_ff, motor_in;
   logic               door_lamp_ff, door_lamp_in;
   logic               stop_lamp_ff, stop_lamp_in;
   logic               floor_ok;
   logic               button_ok;
   mode_type           nm;

   assign floor_ok  = int'(evt.floor) < NUM_FLOORS;
   assign button_ok = int'(evt.button) < NUM_BUTTONS;

   // Next state for the event in the input register.
   always_comb begin
      mode_in      = mode_ff;
      last_dir_in  = last_dir_ff;
      car_floor_in = car_floor_ff;
      orders_in    = orders_ff;
      countdown_in = countdown_ff;
      armed_in     = armed_ff;
      motor_in     = motor_ff;
      door_lamp_in = door_lamp_ff;
      stop_lamp_in = stop_lamp_ff;
      nm           = MODE_CLOSED;

      case (evt.func)
         FUNC_TICK: begin
            if (armed_ff) begin
               if (countdown_ff <= TICKS_W'(1)) begin
                  countdown_in = '0;
                  armed_in     = 1'b0;
                  nm           = next_mode(orders_ff, car_floor_ff, last_dir_ff);
                  if (nm == MODE_DOWN) begin
                     last_dir_in = DIR_DOWN;
                     motor_in    = DIR_DOWN;
                  end else if (nm == MODE_UP) begin
                     last_dir_in = DIR_UP;
                     motor_in    = DIR_UP;
                  end
                  mode_in      = nm;
                  door_lamp_in = 1'b0;
               end else begin
                  countdown_in = countdown_ff - TICKS_W'(1);
               end
            end
         end
         FUNC_SENSOR: begin
            if (floor_ok) begin
               if (mode_ff == MODE_UNKNOWN) begin
                  mode_in      = MODE_CLOSED;
                  motor_in     = DIR_NONE;
                  car_floor_in = evt.floor;
               end else if (mode_ff != MODE_BETWEEN && mode_ff != MODE_STOPPED &&
                            car_floor_ff != evt.floor) begin
                  car_floor_in = evt.floor;
                  if (stop_here(orders_ff, evt.floor, mode_ff)) begin
                     mode_in      = MODE_OPEN;
                     motor_in     = DIR_NONE;
                     door_lamp_in = 1'b1;
                     countdown_in = ticks_ff;
                     armed_in     = 1'b1;
                     for (int i = 0; i < NUM_FLOORS; i++) begin
                        if (i == int'(evt.floor)) begin
                           orders_in[i] = '0;
                        end
                     end
                  end
               end
            end
         end
         FUNC_STOP: begin
            if (mode_ff == MODE_STOPPED) begin
               if (!evt.level) begin
                  mode_in      = MODE_BETWEEN;
                  stop_lamp_in = 1'b0;
               end
            end else if (evt.level) begin
               orders_in = '0;
               if (mode_ff == MODE_DOWN || mode_ff == MODE_UP || mode_ff == MODE_BETWEEN) begin
                  motor_in     = DIR_NONE;
                  mode_in      = MODE_STOPPED;
                  stop_lamp_in = 1'b1;
               end else begin
                  door_lamp_in = 1'b1;
                  mode_in      = MODE_OPEN;
                  countdown_in = ticks_ff;
                  armed_in     = 1'b1;
               end
            end
         end
         FUNC_OBSTR: begin
            if (evt.level && mode_ff == MODE_OPEN) begin
               countdown_in = ticks_ff;
               armed_in     = 1'b1;
            end
         end
         FUNC_ORDER: begin
            if (floor_ok && button_ok && mode_ff != MODE_STOPPED) begin
               for (int i = 0; i < NUM_FLOORS; i++) begin
                  if (i == int'(evt.floor)) begin
                     orders_in[i] = orders_ff[i] |
                                    (row_type'(1) << evt.button);
                  end
               end
               if (mode_ff == MODE_CLOSED || mode_ff == MODE_BETWEEN) begin
                  nm = next_mode(orders_in, car_floor_ff, last_dir_ff);
                  if (nm == MODE_DOWN) begin
                     last_dir_in = DIR_DOWN;
                     motor_in    = DIR_DOWN;
                  end else if (nm == MODE_UP) begin
                     last_dir_in = DIR_UP;
                     motor_in    = DIR_UP;
                  end
                  mode_in      = nm;
                  door_lamp_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result word built from the next state.
   always_comb begin
      rsp.motor_dir       = motor_in;
      rsp.door_lamp       = door_lamp_in;
      rsp.stop_lamp       = stop_lamp_in;
      rsp.floor_indicator = car_floor_in;
      rsp.order_lamps     = '0;
      for (int i = 0; i < SHOWN; i++) begin
         rsp.order_lamps[i*NUM_BUTTONS +: NUM_BUTTONS] = orders_in[i];
      end
      rsp.ctrl_mode       = mode_in;
   end

   // Dwell time register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= DOOR_TICKS_RESET;
      end else if (csr_wr_en) begin
         ticks_ff <= csr_wr_data;
      end
   end

   // Car state advances once per processed event.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNKNOWN;
         last_dir_ff  <= DIR_NONE;
         car_floor_ff <= '0;
         orders_ff    <= '0;
         countdown_ff <= '0;
         armed_ff     <= 1'b0;
         motor_ff     <= DIR_UP;
         door_lamp_ff <= 1'b0;
         stop_lamp_ff <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         last_dir_ff  <= last_dir_in;
         car_floor_ff <= car_floor_in;
         orders_ff    <= orders_in;
         countdown_ff <= countdown_in;
         armed_ff     <= armed_in;
         motor_ff     <= motor_in;
         door_lamp_ff <= door_lamp_in;
         stop_lamp_ff <= stop_lamp_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/ecc_out_stage.sv
// Result register for the response stream.
`timescale 1ns / 1ps
`default_nettype none

module ecc_out_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load,
   input  wire ecc_pkg::rsp_type                 rsp,
   output logic                                  can_take,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ecc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import ecc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   // A new word may enter when the register is empty or being read.
   assign can_take = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp;
      end
   end

   // Pack the result fields, motor direction in the lowest bits.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_ff.ctrl_mode,
                        rsp_ff.order_lamps,
                        rsp_ff.floor_indicator,
                        rsp_ff.stop_lamp,
                        rsp_ff.door_lamp,
                        rsp_ff.motor_dir};

endmodule

`default_nettype wire

>>> sv/elevator_car_controller.sv
// Top level of the single-car elevator controller.
//
//   Port group  Direction  Contents
//   req_*       in         event word: tuser = func, tdata = floor, button, level
//   rsp_*       out        status word: motor, lamps, floor, order lamps, mode
//   csr_*       in         door dwell time in ticks
//
// Each event passes from acceptance through the input register, then through
// the next-state logic into the result register.
// A new event is accepted every cycle unless the result register stalls; the car
// state update sets that rate. Reset is synchronous and needs no clearing pass.
// A stalled result register holds the input register, which then holds req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module elevator_car_controller #(
   parameter int NUM_FLOORS = ecc_pkg::NUM_FLOORS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [1:0] floor, [3:2] button, [4] level, [7:5] zero
   input  wire logic [ecc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] func
   input  wire logic [ecc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] motor_dir, [2] door_lamp, [3] stop_lamp, [5:4] floor_indicator,
   // [17:6] order_lamps, [20:18] ctrl_mode, [23:21] zero
   output logic [ecc_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [ecc_pkg::TICKS_W-1:0]       csr_wr_data
);
   import ecc_pkg::*;

   logic    evt_valid;
   evt_type evt;
   logic    can_take;
   logic    fire;
   rsp_type rsp;

   // An event is processed when the result register can take its word.
   assign fire = evt_valid && can_take;

   ecc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (fire),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   ecc_ctrl #(
      .NUM_FLOORS (NUM_FLOORS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .evt         (evt),
      .rsp         (rsp)
   );

   ecc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .rsp        (rsp),
      .can_take   (can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
